[rtl/wfb_pkg.sv]
// Shared types, status codes and default sizes for the word frequency bucket.
package wfb_pkg;

    localparam int WFB_ENTRIES    = 64;
    localparam int WFB_COUNT_BITS = 32;

    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_INSERT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [63:0] key_part0;
        logic [63:0] key_part1;
        logic [63:0] key_part2;
        logic [63:0] key_part3;
    } wfb_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  entry_index;
        logic [31:0] frequency;
    } wfb_res_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

    typedef struct packed {
        logic       go;
        logic [1:0] op;
    } upd_req_t;

endpackage

[rtl/wfb_scan.sv]
// Key memory and the linear search over the filled entries.
module wfb_scan
    import wfb_pkg::*;
#(
    parameter int   ENTRIES = WFB_ENTRIES,
    localparam int  IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int  FILL_W  = $clog2(ENTRIES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  wfb_req_t          key,
    input  logic [FILL_W-1:0] fill,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    output scan_stat_t        stat,
    output logic [IDX_W-1:0]  hit_idx
);

    wfb_req_t key_mem [ENTRIES];

    wfb_req_t          key_reg;
    wfb_req_t          rd_data_reg;
    logic [IDX_W-1:0]  issue_idx_reg;
    logic [IDX_W-1:0]  issue_idx_next;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  cmp_idx_next;
    logic              issuing_reg;
    logic              issuing_next;
    logic              cmp_valid_reg;
    logic              cmp_valid_next;
    logic              cmp_last_reg;
    logic              cmp_last_next;
    logic              empty_reg;
    logic              empty_next;
    logic              match;
    logic              last_issue;

    assign match      = cmp_valid_reg && (rd_data_reg == key_reg);
    assign last_issue = (FILL_W'(issue_idx_reg) + FILL_W'(1)) == fill;

    assign stat.hit  = match;
    assign stat.done = match || (cmp_valid_reg && cmp_last_reg) || empty_reg;
    assign hit_idx   = cmp_idx_reg;

    always_comb
    begin
        issuing_next   = issuing_reg;
        issue_idx_next = issue_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        cmp_last_next  = cmp_last_reg;
        empty_next     = 1'b0;
        if (go)
        begin
            issuing_next   = (fill != '0);
            empty_next     = (fill == '0);
            issue_idx_next = '0;
        end
        else
        begin
            if (issuing_reg)
            begin
                // one read per cycle, compared in the next cycle
                cmp_valid_next = 1'b1;
                cmp_idx_next   = issue_idx_reg;
                cmp_last_next  = last_issue;
                issue_idx_next = issue_idx_reg + IDX_W'(1);
                issuing_next   = !last_issue;
            end
            if (stat.done)
            begin
                issuing_next   = 1'b0;
                cmp_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            issuing_reg   <= issuing_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            empty_reg     <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        if (go)
        begin
            key_reg <= key;
        end
    end

    // the insert write never overlaps a search read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (issuing_reg)
        begin
            rd_data_reg <= key_mem[issue_idx_reg];
        end
    end

endmodule

[rtl/wfb_update.sv]
// Count memory with read-modify-write and the registered result.
module wfb_update
    import wfb_pkg::*;
#(
    parameter int   ENTRIES    = WFB_ENTRIES,
    parameter int   COUNT_BITS = WFB_COUNT_BITS,
    localparam int  IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  upd_req_t         req,
    input  logic [IDX_W-1:0] idx,
    output logic             result_valid,
    output wfb_res_t         result
);

    logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];

    logic [COUNT_BITS-1:0] rd_cnt_reg;
    logic [COUNT_BITS-1:0] inc;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic                  pend_reg;
    logic                  pend_next;
    logic                  valid_reg;
    logic                  valid_next;
    wfb_res_t              res_reg;
    wfb_res_t              res_next;
    logic                  do_insert;
    logic                  do_found;

    assign do_insert = req.go && (req.op == ST_INSERT);
    assign do_found  = req.go && (req.op == ST_FOUND);

    // saturate at all ones
    assign inc = (rd_cnt_reg == '1) ? rd_cnt_reg : rd_cnt_reg + COUNT_BITS'(1);

    assign pend_next  = do_found;
    assign valid_next = (req.go && (req.op != ST_FOUND)) || pend_reg;

    always_comb
    begin
        res_next.status      = ST_FULL;
        res_next.entry_index = '0;
        res_next.frequency   = '0;
        if (pend_reg)
        begin
            res_next.status      = ST_FOUND;
            res_next.entry_index = 6'(32'(pend_idx_reg));
            res_next.frequency   = 32'(64'(inc));
        end
        else if (do_insert)
        begin
            res_next.status      = ST_INSERT;
            res_next.entry_index = 6'(32'(idx));
            res_next.frequency   = 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (do_found)
        begin
            pend_idx_reg <= idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            cnt_mem[idx] <= COUNT_BITS'(1);
        end
        else if (pend_reg)
        begin
            cnt_mem[pend_idx_reg] <= inc;
        end
        if (do_found)
        begin
            rd_cnt_reg <= cnt_mem[idx];
        end
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule

[rtl/word_frequency_bucket_core.sv]
// Top level of the word frequency bucket: sequencing and fill count.
//
//  channel   strobe / stall     payload   direction
//  request   start / busy       key       in
//  result    result_valid / -   result    out
//
// A request is taken when start is high and busy is low. The search reads the
// filled entries in order from entry 0 through the key memory read port, one
// entry a cycle, and stops at the first hit or after the last filled entry; an
// empty table is answered without a read. Busy falls the cycle after the result
// strobe. Reset empties the table at once. The result is shown for one cycle.
module word_frequency_bucket_core
    import wfb_pkg::*;
#(
    parameter int ENTRIES    = WFB_ENTRIES,
    parameter int COUNT_BITS = WFB_COUNT_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  wfb_req_t key,
    output logic     result_valid,
    output wfb_res_t result
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              go;
    logic              full;
    logic              ins;
    scan_stat_t        stat;
    logic [IDX_W-1:0]  hit_idx;
    upd_req_t          upd;
    logic [IDX_W-1:0]  upd_idx;

    assign busy = (state_reg != S_IDLE);
    assign go   = start && !busy;
    assign full = (fill_reg == FILL_W'(ENTRIES));
    assign ins  = (state_reg == S_SCAN) && stat.done && !stat.hit && !full;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        upd.go     = 1'b0;
        upd.op     = ST_FULL;
        upd_idx    = hit_idx;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.done)
                begin
                    upd.go     = 1'b1;
                    state_next = S_UPD;
                    if (stat.hit)
                    begin
                        upd.op = ST_FOUND;
                    end
                    else if (!full)
                    begin
                        upd.op    = ST_INSERT;
                        upd_idx   = fill_reg[IDX_W-1:0];
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            S_UPD:
            begin
                if (result_valid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    wfb_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .key     (key),
        .fill    (fill_reg),
        .wr_en   (ins),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .stat    (stat),
        .hit_idx (hit_idx)
    );

    wfb_update #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (upd),
        .idx          (upd_idx),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[tb/word_frequency_bucket_core_tb.sv]
// Self-checking bench for the word frequency bucket core: inserts, hits, near misses, full table.
module word_frequency_bucket_core_tb;
    import wfb_pkg::*;

    localparam int ENTRIES     = WFB_ENTRIES;
    localparam int COUNT_BITS  = WFB_COUNT_BITS;
    localparam int PHASE_WORDS = 146;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        wfb_req_t word;
        int       idle_pct;
        bit       drain_first;
    } queued_word_t;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    wfb_req_t key   = '0;
    logic     result_valid;
    wfb_res_t result;

    queued_word_t word_backlog[$];
    wfb_res_t     due_results[$];
    wfb_req_t     word_pool[$];

    // Shadow copy of the bucket
    wfb_req_t              bucket_words[ENTRIES];
    logic [COUNT_BITS-1:0] bucket_counts[ENTRIES];
    int                    bucket_fill  = 0;
    int                    fault_count  = 0;
    int                    quiet_cycles = 0;

    word_frequency_bucket_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .key          (key),
        .result_valid (result_valid),
        .result       (result)
    );

    always #10 clk = ~clk;

    // Look the word up in the shadow bucket, update it and return the result it earns.
    function automatic wfb_res_t tally_word(wfb_req_t w);
        wfb_res_t r;
        int       hit_at = -1;
        r = '0;
        for (int i = 0; i < bucket_fill; i++)
        begin
            if (hit_at < 0 && bucket_words[i] == w)
                hit_at = i;
        end
        if (hit_at >= 0)
        begin
            if (bucket_counts[hit_at] != '1)
                bucket_counts[hit_at] = bucket_counts[hit_at] + COUNT_BITS'(1);
            r.status      = ST_FOUND;
            r.entry_index = hit_at[5:0];
            r.frequency   = 32'(bucket_counts[hit_at]);
        end
        else if (bucket_fill >= ENTRIES)
        begin
            r.status = ST_FULL;
        end
        else
        begin
            bucket_words[bucket_fill]  = w;
            bucket_counts[bucket_fill] = COUNT_BITS'(1);
            r.status      = ST_INSERT;
            r.entry_index = bucket_fill[5:0];
            r.frequency   = 32'd1;
            bucket_fill++;
        end
        return r;
    endfunction

    function automatic void queue_word(wfb_req_t w, int idle_pct, bit drain_first);
        queued_word_t q;
        q.word        = w;
        q.idle_pct    = idle_pct;
        q.drain_first = drain_first;
        word_backlog.push_back(q);
        word_pool.push_back(w);
    endfunction

    // Repeats of known words, fresh words and one-bit near misses; mostly repeats once the pool is large.
    function automatic wfb_req_t pick_word();
        logic [255:0] bits;
        int           roll      = $urandom_range(99);
        int           fresh_pct = (word_pool.size() < ENTRIES + 8) ? 45 : 10;
        int           span;
        if (roll < fresh_pct)
        begin
            bits = {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
            // zero pad like a short word now and then
            case ($urandom_range(3))
                0: bits[191:0] = '0;
                1: bits[127:0] = '0;
                default: ;
            endcase
        end
        else if (roll < fresh_pct + 15)
        begin
            bits = word_pool[$urandom_range(word_pool.size() - 1)];
            span = $urandom_range(255);
            bits[span] = ~bits[span];
        end
        else
        begin
            span = (word_pool.size() < ENTRIES + 16) ? word_pool.size() : ENTRIES + 16;
            bits = word_pool[$urandom_range(span - 1)];
        end
        return wfb_req_t'(bits);
    endfunction

    // Driver: present the next request once the previous one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        logic taken;
        if (!rst_n)
        begin
            start <= 1'b0;
            key   <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
                due_results.push_back(tally_word(key));
            if (!start || taken)
            begin
                if (word_backlog.size() > 0
                    && !(word_backlog[0].drain_first && due_results.size() > 0)
                    && $urandom_range(99) >= word_backlog[0].idle_pct)
                begin
                    start <= 1'b1;
                    key   <= word_backlog[0].word;
                    word_backlog.delete(0);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every strobed result against the oldest outstanding one.
    always @(posedge clk)
    begin
        wfb_res_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d entry_index %0d frequency %0d",
                       result.status, result.entry_index, result.frequency);
                fault_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    fault_count++;
                end
                if (result.entry_index !== want.entry_index)
                begin
                    $error("entry_index: expected %0d, got %0d",
                           want.entry_index, result.entry_index);
                    fault_count++;
                end
                if (result.frequency !== want.frequency)
                begin
                    $error("frequency: expected %0d, got %0d", want.frequency, result.frequency);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog: give up when no request and no result moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid === 1'b1)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [255:0] bits;
        wfb_req_t     w;
        int           idle_pct;

        // Empty table, then all-zero and all-one words and one-bit neighbours in each part
        queue_word('0, 0, 1'b0);
        queue_word('0, 0, 1'b0);
        queue_word('1, 0, 1'b0);
        for (int p = 0; p < 4; p++)
        begin
            bits = '0;
            bits[p * 64 + 63] = 1'b1;
            queue_word(wfb_req_t'(bits), 0, 1'b0);
            bits = '1;
            bits[p * 64] = 1'b0;
            queue_word(wfb_req_t'(bits), 0, 1'b0);
        end
        queue_word('1, 0, 1'b0);
        w = '0;
        w.key_part0 = 64'h0000_006f_6c6c_6568;
        queue_word(w, 0, 1'b0);
        queue_word(w, 0, 1'b0);
        bits = '0;
        bits[63] = 1'b1;
        queue_word(wfb_req_t'(bits), 0, 1'b0);

        // Random phases: no idling, sparse requests, no idling, light idling
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 85 : (ph == 3) ? 26 : 0;
            for (int n = 0; n < PHASE_WORDS; n++)
                queue_word(pick_word(), idle_pct, n == 0 || $urandom_range(39) == 0);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (word_backlog.size() != 0 || start)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);

        if (fault_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/wfb_pkg.sv
rtl/wfb_scan.sv
rtl/wfb_update.sv
rtl/word_frequency_bucket_core.sv
tb/word_frequency_bucket_core_tb.sv
